/* hw/rtl/gn3d_pkg.sv */
`timescale 1ns / 1ps
// gn3d_pkg: shared types, widths and schedule steps of the gradient noise unit
// depends on nothing; imported by every module of the block
package gn3d_pkg;

  localparam int TABLE_SIZE_DEF = 256;
  localparam int FRAC_BITS_DEF  = 16;

  localparam int COORD_W = 24;
  localparam int GRAD_W  = 16;
  localparam int PERM_W  = 8;
  localparam int INDEX_W = 8;
  localparam int OUT_W   = 18;
  localparam int VAL_W   = 20;   // dot products and blends, signed q.15
  localparam int CNT_W   = 5;

  localparam int MUL_A_W_DEF = 22;
  localparam int MUL_B_W_DEF = 18;

  localparam logic signed [VAL_W-1:0] OUT_MAX = 20'sd131071;
  localparam logic signed [VAL_W-1:0] OUT_MIN = -20'sd131072;

  typedef enum logic [1:0] {
    OP_LOAD_PERM = 2'd0,
    OP_LOAD_GRAD = 2'd1,
    OP_SAMPLE    = 2'd2
  } op_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  typedef struct packed {
    logic signed [GRAD_W-1:0] x;
    logic signed [GRAD_W-1:0] y;
    logic signed [GRAD_W-1:0] z;
  } grad_vec_t;

  typedef logic [CNT_W-1:0] step_t;

  // sample schedule
  localparam step_t STEP_Y_FIRST    = 5'd2;   // first y-level permutation read
  localparam step_t STEP_X_FIRST    = 5'd6;   // first x-level permutation read
  localparam step_t STEP_PERM_LAST  = 5'd13;
  localparam step_t STEP_FADE_LAST  = 5'd8;
  localparam step_t STEP_GRD_FIRST  = 5'd8;
  localparam step_t STEP_GRD_LAST   = 5'd15;
  localparam step_t STEP_GMUL_FIRST = 5'd9;
  localparam step_t STEP_GMUL_LAST  = 5'd16;
  localparam step_t STEP_DOT_FIRST  = 5'd10;
  localparam step_t STEP_DOT_LAST   = 5'd17;
  localparam step_t STEP_BX_A       = 5'd18;
  localparam step_t STEP_BX_B       = 5'd19;
  localparam step_t STEP_BY_A       = 5'd20;
  localparam step_t STEP_BY_B       = 5'd21;
  localparam step_t STEP_BY_END     = 5'd22;
  localparam step_t STEP_BZ         = 5'd23;
  localparam step_t STEP_LAST       = 5'd24;

endpackage

/* hw/rtl/gradient_noise_3d_unit.sv */
`timescale 1ns / 1ps
// gradient_noise_3d_unit: 3d gradient noise with quintic fade, table loads and samples
// depends on gn3d_pkg, gn3d_spram (permutation and gradient tables), gn3d_mul_lane
//
//  channel | handshake          | payload
//  --------+--------------------+----------------------------------------------------
//  in      | in_valid/in_stall  | operation index perm_value grad_x/y/z coord_x/y/z
//  out     | out_valid/out_stall| noise_value
//
// a load beat writes its table at the accepting edge and leaves the unit idle
// a sample beat runs through the schedule steps after the accept, with in_stall high; the chain of
// fourteen dependent reads of the single-port permutation memory and the
// eight gradient memory reads set the length of that schedule
// the output register frees the unit once the result is latched; a stalled
// result only holds the last step while out stays full
// rst returns control to idle and drops out_valid; table contents are kept
module gradient_noise_3d_unit import gn3d_pkg::*; #(
  parameter int TABLE_SIZE = TABLE_SIZE_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [1:0]               operation,
  input  logic [INDEX_W-1:0]       index,
  input  logic [PERM_W-1:0]        perm_value,
  input  logic signed [GRAD_W-1:0] grad_x,
  input  logic signed [GRAD_W-1:0] grad_y,
  input  logic signed [GRAD_W-1:0] grad_z,
  input  logic [COORD_W-1:0]       coord_x,
  input  logic [COORD_W-1:0]       coord_y,
  input  logic [COORD_W-1:0]       coord_z,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [OUT_W-1:0]  noise_value
);

  localparam int ADDR_W = $clog2(TABLE_SIZE);
  localparam int FA_W   = FRAC_BITS + 6;            // fade polynomial stays within +-16.0
  localparam int OPA_W  = (FA_W > VAL_W + 2) ? FA_W : VAL_W + 2;
  localparam int OPB_W  = FRAC_BITS + 2;
  localparam int PROD_W = OPA_W + OPB_W;
  localparam int SUM_W  = PROD_W + 2;
  localparam logic signed [FA_W-1:0]  K15   = FA_W'(15 * (2 ** FRAC_BITS));
  localparam logic signed [FA_W-1:0]  K10   = FA_W'(10 * (2 ** FRAC_BITS));
  localparam logic signed [OPB_W-1:0] ONE_B = OPB_W'(2 ** FRAC_BITS);

  // ---------------------------------------------------------------- control
  state_t state, state_next;
  step_t  cnt, cnt_next;
  logic   in_accept, out_free, done;
  op_t    op_in;

  assign op_in     = op_t'(operation);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign done      = (state == ST_RUN) && (cnt == STEP_LAST) && out_free;

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    unique case (state)
      ST_IDLE: begin
        cnt_next = '0;
        if (in_accept && op_in == OP_SAMPLE) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (cnt != STEP_LAST) begin
          cnt_next = cnt + CNT_W'(1);
        end else if (out_free) begin
          state_next = ST_IDLE;
          cnt_next   = '0;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = (state != ST_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  // ---------------------------------------------------------------- sample setup
  logic [COORD_W+ADDR_W-1:0] cx_ext, cy_ext, cz_ext;
  logic [INDEX_W+ADDR_W-1:0] idx_ext;
  logic [ADDR_W-1:0]         load_addr;
  logic [ADDR_W-1:0]         cell_x, cell_y, cell_z;
  logic [FRAC_BITS-1:0]      frac_x, frac_y, frac_z;

  assign cx_ext    = {{ADDR_W{1'b0}}, coord_x};
  assign cy_ext    = {{ADDR_W{1'b0}}, coord_y};
  assign cz_ext    = {{ADDR_W{1'b0}}, coord_z};
  assign idx_ext   = {{ADDR_W{1'b0}}, index};
  assign load_addr = idx_ext[ADDR_W-1:0];

  // integer cell wraps on the table size, fraction kept for offsets and fade
  always_ff @(posedge clk) begin
    if (in_accept && op_in == OP_SAMPLE) begin
      cell_x <= cx_ext[FRAC_BITS +: ADDR_W];
      cell_y <= cy_ext[FRAC_BITS +: ADDR_W];
      cell_z <= cz_ext[FRAC_BITS +: ADDR_W];
      frac_x <= coord_x[FRAC_BITS-1:0];
      frac_y <= coord_y[FRAC_BITS-1:0];
      frac_z <= coord_z[FRAC_BITS-1:0];
    end
  end

  // ---------------------------------------------------------------- tables
  logic              perm_we, grad_we;
  logic [ADDR_W-1:0] perm_addr, perm_raddr, grad_addr, grad_raddr;
  logic [PERM_W-1:0] perm_rdata;
  grad_vec_t         grad_wdata, grad_rdata;

  assign perm_we    = in_accept && op_in == OP_LOAD_PERM;
  assign grad_we    = in_accept && op_in == OP_LOAD_GRAD;
  assign perm_addr  = perm_we ? load_addr : perm_raddr;
  assign grad_addr  = grad_we ? load_addr : grad_raddr;
  assign grad_wdata = '{x: grad_x, y: grad_y, z: grad_z};

  gn3d_spram #(
    .WIDTH (PERM_W),
    .DEPTH (TABLE_SIZE),
    .ADDR_W(ADDR_W)
  ) u_perm_ram (
    .clk  (clk),
    .we   (perm_we),
    .addr (perm_addr),
    .wdata(perm_value),
    .rdata(perm_rdata)
  );

  gn3d_spram #(
    .WIDTH ($bits(grad_vec_t)),
    .DEPTH (TABLE_SIZE),
    .ADDR_W(ADDR_W)
  ) u_grad_ram (
    .clk  (clk),
    .we   (grad_we),
    .addr (grad_addr),
    .wdata(grad_wdata),
    .rdata(grad_rdata)
  );

  // ---------------------------------------------------------------- hashing
  // reads: z0 z1, then y0/y1 on each z hash, then x0/x1 on each yz hash;
  // every read depends on a hash that already sits in its capture register when
  // the read is issued, so no bypass of the read data is needed
  logic [PERM_W-1:0] hz [2];
  logic [PERM_W-1:0] hy [4];
  logic [PERM_W-1:0] hx [8];
  logic [ADDR_W-1:0] cell_x1, cell_y1, cell_z1;
  step_t             off_y, off_x, off_g, cap_z, cap_y, cap_x;
  logic [PERM_W+ADDR_W-1:0] gsel_ext;

  function automatic logic [ADDR_W-1:0] hadd(logic [ADDR_W-1:0] c, logic [PERM_W-1:0] h);
    logic [ADDR_W+PERM_W-1:0] s;
    s = {{PERM_W{1'b0}}, c} + {{ADDR_W{1'b0}}, h};
    return s[ADDR_W-1:0];
  endfunction

  assign cell_x1 = cell_x + ADDR_W'(1);
  assign cell_y1 = cell_y + ADDR_W'(1);
  assign cell_z1 = cell_z + ADDR_W'(1);
  assign off_y   = cnt - STEP_Y_FIRST;
  assign off_x   = cnt - STEP_X_FIRST;
  assign off_g   = cnt - STEP_GRD_FIRST;
  assign cap_z   = cnt - CNT_W'(1);
  assign cap_y   = cnt - STEP_Y_FIRST - CNT_W'(1);
  assign cap_x   = cnt - STEP_X_FIRST - CNT_W'(1);

  always_comb begin
    perm_raddr = '0;
    if (cnt < STEP_Y_FIRST) begin
      perm_raddr = cnt[0] ? cell_z1 : cell_z;
    end else if (cnt < STEP_X_FIRST) begin
      perm_raddr = hadd(off_y[0] ? cell_y1 : cell_y, hz[off_y[1]]);
    end else if (cnt <= STEP_PERM_LAST) begin
      perm_raddr = hadd(off_x[0] ? cell_x1 : cell_x, hy[off_x[2:1]]);
    end
  end

  // corner k of the gradient reads: bit 0 picks x1, bit 1 y1, bit 2 z1
  assign gsel_ext   = {{ADDR_W{1'b0}}, hx[off_g[2:0]]};
  assign grad_raddr = gsel_ext[ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (state == ST_RUN) begin
      if (cnt >= CNT_W'(1) && cnt <= STEP_Y_FIRST) begin
        hz[cap_z[0]] <= perm_rdata;
      end else if (cnt > STEP_Y_FIRST && cnt <= STEP_X_FIRST) begin
        hy[cap_y[1:0]] <= perm_rdata;
      end else if (cnt > STEP_X_FIRST && cnt <= STEP_PERM_LAST + CNT_W'(1)) begin
        hx[cap_x[2:0]] <= perm_rdata;
      end
    end
  end

  // ---------------------------------------------------------------- arithmetic
  logic                      mul_en [3];
  logic signed [OPA_W-1:0]   mul_a  [3];
  logic signed [OPB_W-1:0]   mul_b  [3];
  logic signed [PROD_W-1:0]  mul_p  [3];
  logic signed [FA_W-1:0]    fa     [3];
  logic [FRAC_BITS-1:0]      frac   [3];
  logic signed [VAL_W-1:0]   dot    [8];
  logic signed [VAL_W-1:0]   bx     [4];
  logic signed [VAL_W-1:0]   by     [2];
  logic signed [OPB_W-1:0]   wgt    [3];
  logic signed [OPB_W-1:0]   pos    [3];
  logic signed [OPB_W-1:0]   neg    [3];
  logic signed [GRAD_W-1:0]  gcomp  [3];
  logic signed [SUM_W-1:0]   dsum, dsum_sh;
  logic signed [VAL_W-1:0]   vsum;
  step_t                     off_m, off_d;

  assign frac[0]  = frac_x;
  assign frac[1]  = frac_y;
  assign frac[2]  = frac_z;
  assign gcomp[0] = grad_rdata.x;
  assign gcomp[1] = grad_rdata.y;
  assign gcomp[2] = grad_rdata.z;
  assign off_m    = cnt - STEP_GMUL_FIRST;
  assign off_d    = cnt - STEP_DOT_FIRST;

  function automatic logic signed [VAL_W-1:0] scale(logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] s;
    s = p >>> FRAC_BITS;
    return s[VAL_W-1:0];
  endfunction

  function automatic logic signed [FA_W-1:0] fscale(logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] s;
    s = p >>> FRAC_BITS;
    return s[FA_W-1:0];
  endfunction

  function automatic logic signed [OPA_W-1:0] diff(logic signed [VAL_W-1:0] b,
                                                   logic signed [VAL_W-1:0] a);
    return OPA_W'(b) - OPA_W'(a);
  endfunction

  for (genvar i = 0; i < 3; i++) begin : g_lane
    assign wgt[i] = fa[i][OPB_W-1:0];
    assign pos[i] = {2'b00, frac[i]};
    assign neg[i] = pos[i] - ONE_B;

    gn3d_mul_lane #(
      .A_W(OPA_W),
      .B_W(OPB_W)
    ) u_lane (
      .clk(clk),
      .en (mul_en[i]),
      .a  (mul_a[i]),
      .b  (mul_b[i]),
      .p  (mul_p[i])
    );
  end

  // lane operands: fade terms early, corner dot products, then the blends
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mul_en[i] = 1'b0;
      mul_a[i]  = '0;
      mul_b[i]  = '0;
    end
    if (state == ST_RUN) begin
      if (cnt <= STEP_FADE_LAST && cnt[0]) begin
        for (int i = 0; i < 3; i++) begin
          mul_en[i] = 1'b1;
          mul_a[i]  = OPA_W'(fa[i]);
          mul_b[i]  = pos[i];
        end
      end else if (cnt >= STEP_GMUL_FIRST && cnt <= STEP_GMUL_LAST) begin
        for (int i = 0; i < 3; i++) begin
          mul_en[i] = 1'b1;
          mul_a[i]  = OPA_W'(gcomp[i]);
          mul_b[i]  = off_m[i] ? neg[i] : pos[i];
        end
      end else begin
        case (cnt)
          STEP_BX_A: begin
            for (int i = 0; i < 3; i++) begin
              mul_en[i] = 1'b1;
              mul_a[i]  = diff(dot[2*i+1], dot[2*i]);
              mul_b[i]  = wgt[0];
            end
          end
          STEP_BX_B: begin
            mul_en[0] = 1'b1;
            mul_a[0]  = diff(dot[7], dot[6]);
            mul_b[0]  = wgt[0];
          end
          STEP_BY_A: begin
            mul_en[0] = 1'b1;
            mul_a[0]  = diff(bx[1], bx[0]);
            mul_b[0]  = wgt[1];
          end
          STEP_BY_B: begin
            mul_en[1] = 1'b1;
            mul_a[1]  = diff(bx[3], bx[2]);
            mul_b[1]  = wgt[1];
          end
          STEP_BZ: begin
            mul_en[0] = 1'b1;
            mul_a[0]  = diff(by[1], by[0]);
            mul_b[0]  = wgt[2];
          end
          default: ;
        endcase
      end
    end
  end

  // dot sum is exact, then one floor shift back to q.15
  assign dsum    = SUM_W'(mul_p[0]) + SUM_W'(mul_p[1]) + SUM_W'(mul_p[2]);
  assign dsum_sh = dsum >>> FRAC_BITS;
  assign vsum    = by[0] + scale(mul_p[0]);

  always_ff @(posedge clk) begin
    if (state == ST_RUN) begin
      // fade ((((6t - 15)t + 10)t)t)t, one product issued on each odd step
      if (cnt == '0) begin
        for (int i = 0; i < 3; i++) begin
          fa[i] <= (FA_W'(pos[i]) <<< 2) + (FA_W'(pos[i]) <<< 1) - K15;
        end
      end else if (cnt == CNT_W'(2)) begin
        for (int i = 0; i < 3; i++) begin
          fa[i] <= fscale(mul_p[i]) + K10;
        end
      end else if (cnt <= STEP_FADE_LAST && !cnt[0]) begin
        for (int i = 0; i < 3; i++) begin
          fa[i] <= fscale(mul_p[i]);
        end
      end
      if (cnt >= STEP_DOT_FIRST && cnt <= STEP_DOT_LAST) begin
        dot[off_d[2:0]] <= dsum_sh[VAL_W-1:0];
      end
      case (cnt)
        STEP_BX_B: begin
          bx[0] <= dot[0] + scale(mul_p[0]);
          bx[1] <= dot[2] + scale(mul_p[1]);
          bx[2] <= dot[4] + scale(mul_p[2]);
        end
        STEP_BY_A:   bx[3] <= dot[6] + scale(mul_p[0]);
        STEP_BY_B:   by[0] <= bx[0] + scale(mul_p[0]);
        STEP_BY_END: by[1] <= bx[2] + scale(mul_p[1]);
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      if (vsum > OUT_MAX) begin
        noise_value <= OUT_MAX[OUT_W-1:0];
      end else if (vsum < OUT_MIN) begin
        noise_value <= OUT_MIN[OUT_W-1:0];
      end else begin
        noise_value <= vsum[OUT_W-1:0];
      end
    end
  end

  // ---------------------------------------------------------------- checks
  a_result_from_last_step: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_RUN && cnt == STEP_LAST))
    else $error("result raised outside the last schedule step");

  a_no_table_write_in_run: assert property (@(posedge clk) disable iff (rst)
    state == ST_RUN |-> !perm_we && !grad_we)
    else $error("table written while a sample is reading it");

  a_hold_on_full_output: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN && cnt == STEP_LAST && out_valid && out_stall)
      |=> (state == ST_RUN && cnt == STEP_LAST && $stable(noise_value)))
    else $error("last step left while the result register was full");

  a_step_in_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> cnt == '0)
    else $error("schedule step not cleared in idle");

endmodule

/* hw/rtl/gn3d_spram.sv */
`timescale 1ns / 1ps
// gn3d_spram: single-port synchronous table memory, read-first, registered read data
// depends on gn3d_pkg for default sizes
module gn3d_spram import gn3d_pkg::*; #(
  parameter int WIDTH  = PERM_W,
  parameter int DEPTH  = TABLE_SIZE_DEF,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] addr,
  input  logic [WIDTH-1:0]  wdata,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

/* hw/rtl/gn3d_mul_lane.sv */
`timescale 1ns / 1ps
// gn3d_mul_lane: signed multiplier with registered product, loads only when enabled
// depends on gn3d_pkg for default widths
module gn3d_mul_lane import gn3d_pkg::*; #(
  parameter int A_W = MUL_A_W_DEF,
  parameter int B_W = MUL_B_W_DEF
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [A_W-1:0]   a,
  input  logic signed [B_W-1:0]   b,
  output logic signed [A_W+B_W-1:0] p
);

  always_ff @(posedge clk) begin
    if (en) begin
      p <= a * b;
    end
  end

endmodule
